### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that cond implies prop at the same edge outside reset.
`define ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

### rtl/core/lpm_pkg.sv
package lpm_pkg;

   localparam int CAPACITY_C = 1024;
   localparam int ADDR_W     = $clog2(CAPACITY_C);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int LAT_W      = 32;
   localparam int METRICS_C  = 4;
   localparam int LANES_C    = 3;
   localparam int WORD_W     = LAT_W * METRICS_C;
   localparam int XW         = 17;
   localparam int RECIP_SH   = 24;
   localparam logic [17:0] RECIP_100 = 18'd167773;

   localparam logic [1:0] CSR_ENABLE   = 2'd0;
   localparam logic [1:0] CSR_CAPACITY = 2'd1;
   localparam logic [1:0] CSR_INTERVAL = 2'd2;

   localparam logic [1:0] METRIC_LAST = 2'd3;

   typedef logic [6:0] rank_k_type [LANES_C];
   localparam rank_k_type RANK_K = '{7'd50, 7'd95, 7'd99};

   typedef struct packed {
      logic accept;
      logic rank_a;
      logic rank_b;
      logic init_metric;
      logic scan;
      logic eval;
      logic next_metric;
   } lpm_cmd_type;

   typedef struct packed {
      logic report_due;
      logic idx_last;
      logic bit_last;
      logic metric_last;
   } lpm_stat_type;

endpackage

### rtl/core/latency_percentile_monitor_top.sv
// Latency percentile monitor. Each req_ transfer carries four frame latencies and a
// millisecond time stamp; while enabled they are stored in a ring of up to 1024
// entries, and once report_interval milliseconds have passed since the last report
// the block returns four rsp_ transfers (capture, encode, send, total) carrying the
// nearest-rank p50, p95 and p99 over the kept samples. Between reports the block
// accepts a new sample every clock. The radix-select sequencer makes one pass over
// the store per result bit through the single read port of the sample RAM, all
// three ranks resolved in that pass.
// req_stall stays high for the whole report. A configuration write clears the
// sample count and the ring cursor.
`include "assert_macros.svh"

module latency_percentile_monitor_top
   import lpm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [LAT_W-1:0] req_capture_lat,
   input  logic [LAT_W-1:0] req_encode_lat,
   input  logic [LAT_W-1:0] req_send_lat,
   input  logic [LAT_W-1:0] req_total_lat,
   input  logic [LAT_W-1:0] req_time_now,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_metric_id,
   output logic [LAT_W-1:0] rsp_median_val,
   output logic [LAT_W-1:0] rsp_p95_val,
   output logic [LAT_W-1:0] rsp_p99_val,
   output logic [CNT_W-1:0] rsp_sample_total,
   output logic             rsp_last_metric,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [LAT_W-1:0] csr_data
);

   lpm_cmd_type  cmd;
   lpm_stat_type stat;

   // Sequence store, rank setup, bit passes and result transfers.
   lpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the ring, the configuration and the three select lanes.
   lpm_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .capture_lat  (req_capture_lat),
      .encode_lat   (req_encode_lat),
      .send_lat     (req_send_lat),
      .total_lat    (req_total_lat),
      .time_now     (req_time_now),
      .metric_id    (rsp_metric_id),
      .median_val   (rsp_median_val),
      .p95_val      (rsp_p95_val),
      .p99_val      (rsp_p99_val),
      .sample_total (rsp_sample_total),
      .last_metric  (rsp_last_metric)
   );

   `ASSERT_IMPL(a_rsp_blocks_req, clock, reset, rsp_valid, req_stall, "result shown while input open")
   `ASSERT_IMPL(a_rsp_count, clock, reset, rsp_valid, rsp_sample_total != '0, "report over no samples")
   `ASSERT_IMPL(a_rsp_order, clock, reset, rsp_valid, (rsp_median_val <= rsp_p95_val) && (rsp_p95_val <= rsp_p99_val), "percentiles out of order")
   `ASSERT_CLK(a_rsp_end, clock, reset, rsp_valid && !rsp_stall && rsp_last_metric |=> !rsp_valid, "result after last metric")

endmodule

### rtl/core/lpm_ram.sv
module lpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### rtl/core/lpm_ctrl.sv
module lpm_ctrl
   import lpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  lpm_stat_type stat,
   output lpm_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RANKA = 3'd1;
   localparam logic [2:0] ST_RANKB = 3'd2;
   localparam logic [2:0] ST_INIT  = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_TAIL  = 3'd5;
   localparam logic [2:0] ST_EVAL  = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = accept;
            if (accept && stat.report_due) begin
               state_in = ST_RANKA;
            end
         end
         ST_RANKA: begin
            cmd.rank_a = 1'b1;
            state_in   = ST_RANKB;
         end
         ST_RANKB: begin
            cmd.rank_b = 1'b1;
            state_in   = ST_INIT;
         end
         ST_INIT: begin
            cmd.init_metric = 1'b1;
            state_in        = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.idx_last) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = stat.bit_last ? ST_OUT : ST_SCAN;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (stat.metric_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_metric = 1'b1;
                  state_in        = ST_INIT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/lpm_datapath.sv
module lpm_datapath
   import lpm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  lpm_cmd_type        cmd,
   output lpm_stat_type       stat,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [LAT_W-1:0]   csr_data,
   input  logic [LAT_W-1:0]   capture_lat,
   input  logic [LAT_W-1:0]   encode_lat,
   input  logic [LAT_W-1:0]   send_lat,
   input  logic [LAT_W-1:0]   total_lat,
   input  logic [LAT_W-1:0]   time_now,
   output logic [1:0]         metric_id,
   output logic [LAT_W-1:0]   median_val,
   output logic [LAT_W-1:0]   p95_val,
   output logic [LAT_W-1:0]   p99_val,
   output logic [CNT_W-1:0]   sample_total,
   output logic               last_metric
);

   logic              enable_ff;
   logic [CNT_W-1:0]  capacity_ff;
   logic [LAT_W-1:0]  interval_ff;
   logic [ADDR_W-1:0] cursor_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [LAT_W-1:0]  last_time_ff;
   logic [1:0]        metric_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic              rd_valid_ff;
   logic [LAT_W-1:0]  mask_ff, bit_ff;
   logic [XW-1:0]     x_ff      [LANES_C];
   logic [CNT_W-1:0]  base_ff   [LANES_C];
   logic [CNT_W-1:0]  rank_ff   [LANES_C];
   logic [CNT_W-1:0]  zeros_ff  [LANES_C];
   logic [LAT_W-1:0]  prefix_ff [LANES_C];

   logic [CNT_W-1:0]  cap_eff, cursor_ext, cursor_inc, count_in;
   logic [ADDR_W-1:0] cursor_eff, cursor_in;
   logic [LAT_W-1:0]  elapsed, sel_val;
   logic [WORD_W-1:0] rd_data;
   logic              store;

   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (capacity_ff > CNT_W'(CAPACITY_C)) begin
         cap_eff = CNT_W'(CAPACITY_C);
      end else begin
         cap_eff = capacity_ff;
      end
      cursor_ext = {1'b0, cursor_ff};
      cursor_eff = (cursor_ext >= cap_eff) ? '0 : cursor_ff;
      cursor_inc = {1'b0, cursor_eff} + CNT_W'(1);
      cursor_in  = (cursor_inc == cap_eff) ? '0 : cursor_inc[ADDR_W-1:0];
      count_in   = (count_ff < cap_eff) ? count_ff + CNT_W'(1) : cap_eff;
   end

   assign store   = cmd.accept && enable_ff;
   assign elapsed = time_now - last_time_ff;

   assign stat.report_due  = enable_ff && (interval_ff != '0) && (elapsed >= interval_ff);
   assign stat.idx_last    = ({1'b0, idx_ff} == count_ff - CNT_W'(1));
   assign stat.bit_last    = bit_ff[0];
   assign stat.metric_last = (metric_ff == METRIC_LAST);

   lpm_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY_C)) u_store (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (cursor_eff),
      .wr_data ({total_lat, send_lat, encode_lat, capture_lat}),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign sel_val = rd_data[metric_ff*LAT_W +: LAT_W];

   // Control and configuration state.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         capacity_ff  <= CNT_W'(CAPACITY_C);
         interval_ff  <= '0;
         cursor_ff    <= '0;
         count_ff     <= '0;
         last_time_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan;
         if (csr_write && (csr_index == CSR_ENABLE || csr_index == CSR_CAPACITY ||
                           csr_index == CSR_INTERVAL)) begin
            cursor_ff <= '0;
            count_ff  <= '0;
            unique case (csr_index)
               CSR_ENABLE:   enable_ff   <= csr_data[0];
               CSR_CAPACITY: capacity_ff <= csr_data[CNT_W-1:0];
               default:      interval_ff <= csr_data;
            endcase
         end else if (store) begin
            cursor_ff <= cursor_in;
            count_ff  <= count_in;
            if (stat.report_due) begin
               last_time_ff <= time_now;
            end
         end
      end
   end

   // Radix select: one bit per pass over the kept samples, three ranks at once.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         metric_ff <= '0;
      end else if (cmd.next_metric) begin
         metric_ff <= metric_ff + 2'd1;
      end
      if (cmd.init_metric || cmd.eval) begin
         idx_ff <= '0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + ADDR_W'(1);
      end
      if (cmd.init_metric) begin
         mask_ff <= '0;
         bit_ff  <= {1'b1, {(LAT_W-1){1'b0}}};
      end else if (cmd.eval) begin
         mask_ff <= {1'b1, mask_ff[LAT_W-1:1]};
         bit_ff  <= {1'b0, bit_ff[LAT_W-1:1]};
      end
      for (int l = 0; l < LANES_C; l++) begin
         if (cmd.rank_a) begin
            x_ff[l] <= XW'(RANK_K[l] * count_ff) + XW'(99);
         end
         if (cmd.rank_b) begin
            base_ff[l] <= CNT_W'(((35'(x_ff[l]) * 35'(RECIP_100)) >> RECIP_SH)) - CNT_W'(1);
         end
         if (cmd.init_metric) begin
            rank_ff[l]   <= base_ff[l];
            prefix_ff[l] <= '0;
            zeros_ff[l]  <= '0;
         end else if (cmd.eval) begin
            zeros_ff[l] <= '0;
            if (rank_ff[l] >= zeros_ff[l]) begin
               prefix_ff[l] <= prefix_ff[l] | bit_ff;
               rank_ff[l]   <= rank_ff[l] - zeros_ff[l];
            end
         end else if (rd_valid_ff && ((sel_val & mask_ff) == prefix_ff[l]) &&
                      ((sel_val & bit_ff) == '0)) begin
            zeros_ff[l] <= zeros_ff[l] + CNT_W'(1);
         end
      end
   end

   assign metric_id    = metric_ff;
   assign median_val   = prefix_ff[0];
   assign p95_val      = prefix_ff[1];
   assign p99_val      = prefix_ff[2];
   assign sample_total = count_ff;
   assign last_metric  = stat.metric_last;

endmodule
